// File: design/bfxwc_pkg.sv
// Package: shared types and constants for the byte feedback XOR word cipher.
package bfxwc_pkg;

    localparam int NumStages = 7;
    localparam int KeyW      = 16;
    localparam int WordW     = 32;
    localparam int CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] CfgConstKey1 = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgConstKey2 = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgDynKey    = 2'd2;

    localparam logic [WordW-1:0] RstConstKey1 = 32'd2366183;
    localparam logic [WordW-1:0] RstConstKey2 = 32'd1432754;
    localparam logic [WordW-1:0] RstDynKey    = 32'd79984829;

    // Bits 15:8 of the running key only ever depend on its low 16 bits.
    typedef struct packed {
        logic             op;
        logic [WordW-1:0] data;
        logic [KeyW-1:0]  key;
    } stage_t;

endpackage

// File: design/byte_feedback_xor_word_cipher_top.sv
// Top level: seven-stage pipelined byte feedback XOR word cipher.
//
// One word enters per clock while the output side keeps taking, and each word
// passes through every stage in turn; the depth comes from the three key
// updates, each a 16x16 multiply with its own register stage, between the four
// byte XOR stages. Stages advance independently, so bubbles close up and new
// words are taken while a finished result waits. Only the low 16 bits of the
// key registers reach the datapath, since key bits 15:8 never depend on
// higher bits. Configuration writes take effect at once and belong to idle time.
module byte_feedback_xor_word_cipher_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bfxwc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [bfxwc_pkg::WordW-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [bfxwc_pkg::WordW-1:0]       s_data_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bfxwc_pkg::WordW-1:0]       m_result_word
);

    localparam int N = bfxwc_pkg::NumStages;
    localparam int KW = bfxwc_pkg::KeyW;

    logic [KW-1:0] key1_reg, key2_reg, dyn_reg;

    bfxwc_pkg::stage_t stage_reg [N];
    bfxwc_pkg::stage_t stage_next [N];
    bfxwc_pkg::stage_t stage_src [N];
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key1_reg <= bfxwc_pkg::RstConstKey1[KW-1:0];
            key2_reg <= bfxwc_pkg::RstConstKey2[KW-1:0];
            dyn_reg  <= bfxwc_pkg::RstDynKey[KW-1:0];
        end else if (cfg_we) begin
            case (cfg_index)
                bfxwc_pkg::CfgConstKey1: key1_reg <= cfg_data[KW-1:0];
                bfxwc_pkg::CfgConstKey2: key2_reg <= cfg_data[KW-1:0];
                bfxwc_pkg::CfgDynKey:    dyn_reg  <= cfg_data[KW-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        en[N-1] = !valid_reg[N-1] || m_ready;
        for (int i = N - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            if (s == 0) begin : g_src_in
                assign stage_src[s] = '{op: s_opcode, data: s_data_word, key: dyn_reg};
            end else begin : g_src_prev
                assign stage_src[s] = stage_reg[s-1];
            end

            if ((s % 2) == 0) begin : g_xor
                localparam int B = s / 2;
                logic [7:0] in_byte, out_byte, fb_byte;
                always_comb begin
                    in_byte  = stage_src[s].data[8*B +: 8];
                    out_byte = in_byte ^ stage_src[s].key[15:8];
                    fb_byte  = stage_src[s].op ? in_byte : out_byte;
                    stage_next[s]              = stage_src[s];
                    stage_next[s].data[8*B +: 8] = out_byte;
                    stage_next[s].key          = stage_src[s].key + {{(KW-8){1'b0}}, fb_byte};
                end
            end else begin : g_mul
                logic [KW-1:0] prod;
                always_comb begin
                    prod              = stage_src[s].key * key1_reg;
                    stage_next[s]     = stage_src[s];
                    stage_next[s].key = prod + key2_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en[s]) begin
                    valid_reg[s] <= (s == 0) ? s_valid : valid_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en[s]) begin
                    stage_reg[s] <= stage_next[s];
                end
            end
        end
    endgenerate

    assign m_valid       = valid_reg[N-1];
    assign m_result_word = stage_reg[N-1].data;

endmodule

// File: design/bfxwc_checker.sv
// Checker: port-level assertions for the cipher top level, with its bind.
module bfxwc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bfxwc_pkg::WordW-1:0]   m_result_word
);

    // Output side empties after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_word))
        else $error("stalled result changed");

    // A taken or empty output slot lets the whole pipe move.
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output side free");

    // With no back-pressure an accepted word comes out of the last stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("accepted transaction did not emerge");

endmodule

bind byte_feedback_xor_word_cipher_top bfxwc_checker u_bfxwc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_word (m_result_word)
);
